@@ hdl/pfx_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfx_pkg: shared types and constants of the postfix evaluator
// Word formats, symbol codes, operation and status codes, controller links.
// ----------------------------------------------------------------------------
package pfx_pkg;

    // Stack geometry
    localparam int STACK_DEPTH = 16;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // Divider
    localparam int DATA_W    = 32;
    localparam int DIV_STEPS = DATA_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    // Character codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_TIMES = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNDER = 2'd1;
    localparam logic [1:0] ST_OVER  = 2'd2;
    localparam logic [1:0] ST_DIVZ  = 2'd3;

    // Decoded operation codes
    typedef logic [2:0] t_op;
    localparam t_op OP_DIGIT = 3'd0;
    localparam t_op OP_ADD   = 3'd1;
    localparam t_op OP_SUB   = 3'd2;
    localparam t_op OP_MUL   = 3'd3;
    localparam t_op OP_DIV   = 3'd4;
    localparam t_op OP_NONE  = 3'd5;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last_symbol;
    } t_in_word;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [1:0]               status;
    } t_out_word;

    // Controller to datapath
    typedef struct packed {
        logic load_in;
        logic set_digit;
        logic pop;
        logic latch_right;
        logic latch_left;
        logic alu;
        logic divz;
        logic div_start;
        logic load_quot;
        logic push;
        logic finish;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        t_op  op;
        logic last;
        logic right_zero;
        logic div_done;
        logic out_free;
    } t_stat;

endpackage

@@ hdl/postfix_expression_evaluator.sv @@
// Each word is evaluated in full before the next one is accepted: digits
// are pushed directly, other characters pop two operands first, and / waits
// on the iterative divider unless the divisor is zero.
// On a last word the final pop shares the end step, then the output
// register loads once the previous result has left it.
// Reset (i_rst_n low, synchronous): empty stack, no error, no result pending.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// postfix_expression_evaluator: top level
// Evaluates a postfix expression fed one character word at a time over a
// 16-entry operand stack with sticky underflow, overflow and divide-by-zero
// status, and delivers one value/status word per expression.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator
    import pfx_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    // input word channel
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    // result word channel
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    // Command and status between sequencer and datapath
    t_cmd  w_cmd;
    t_stat w_stat;

    // Sequencer: holds the input stalled while a word is being evaluated,
    // and waits in its final step until the output register is free.
    pfx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Datapath: stack memory with registered read, ALU with a combinational
    // multiplier, iterative divider, and the output word register that
    // decouples the result channel from the input side.
    pfx_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_word   (i_in_word),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

    // A word loads only when offered and the input is not stalled: nothing loads while busy
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_in |-> (i_in_valid && !o_in_stall))
        else $error("input loaded while stalled");

endmodule

@@ hdl/pfx_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfx_div: iterative signed divider
// Restoring divide on magnitudes, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module pfx_div
    import pfx_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_dividend,
    input  logic [DATA_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DATA_W-1:0] o_quot
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [DCNT_W-1:0] r_cnt,  n_cnt;
    logic [DATA_W-1:0] r_quo,  n_quo;
    logic [DATA_W-1:0] r_rem,  n_rem;
    logic [DATA_W-1:0] r_dvs,  n_dvs;
    logic              r_neg,  n_neg;

    logic [DATA_W:0]   w_shift;
    logic [DATA_W:0]   w_diff;

    assign w_shift = {r_rem, r_quo[DATA_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_neg  = r_neg;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_neg  = i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
            n_quo  = i_dividend[DATA_W-1] ? (~i_dividend + 1'b1) : i_dividend;
            n_dvs  = i_divisor[DATA_W-1]  ? (~i_divisor + 1'b1)  : i_divisor;
        end else if (r_busy) begin
            // subtract when the trial remainder covers the divisor
            if (!w_diff[DATA_W]) begin
                n_rem = w_diff[DATA_W-1:0];
                n_quo = {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                n_rem = w_shift[DATA_W-1:0];
                n_quo = {r_quo[DATA_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DCNT_W'(DIV_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_neg <= n_neg;
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? (~r_quo + 1'b1) : r_quo;

endmodule

@@ hdl/pfx_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfx_dpath: operand stack and arithmetic
// Stack memory, pointer, sticky error, operand registers, ALU, divider and
// the output word register.
// ----------------------------------------------------------------------------
module pfx_dpath
    import pfx_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    output t_stat     o_stat,
    input  t_in_word  i_in_word,
    input  logic      i_out_stall,
    output logic      o_out_valid,
    output t_out_word o_out_word
);

    logic [DATA_W-1:0] r_stack [STACK_DEPTH];

    logic [SP_W-1:0]   r_sp,  n_sp;
    logic [1:0]        r_err, n_err;
    logic [7:0]        r_sym;
    logic              r_last;
    logic [DATA_W-1:0] r_rd;
    logic              r_rd_zero;
    logic [DATA_W-1:0] r_right;
    logic [DATA_W-1:0] r_left;
    logic [DATA_W-1:0] r_res;
    logic              r_out_valid;
    t_out_word         r_out_word;

    logic [SP_W-1:0]   w_sp_dec;
    logic              w_empty;
    logic              w_full;
    logic [DATA_W-1:0] w_opnd;
    logic              w_div_done;
    logic [DATA_W-1:0] w_quot;
    t_op               w_op;

    assign w_sp_dec = r_sp - 1'b1;
    assign w_empty  = (r_sp == '0);
    assign w_full   = (r_sp >= SP_W'(STACK_DEPTH));
    assign w_opnd   = r_rd_zero ? '0 : r_rd;

    // symbol decode
    always_comb begin
        if (r_sym >= CH_ZERO && r_sym <= CH_NINE) begin
            w_op = OP_DIGIT;
        end else begin
            unique case (r_sym)
                CH_PLUS:  w_op = OP_ADD;
                CH_MINUS: w_op = OP_SUB;
                CH_TIMES: w_op = OP_MUL;
                CH_SLASH: w_op = OP_DIV;
                default:  w_op = OP_NONE;
            endcase
        end
    end

    pfx_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_left),
        .i_divisor  (r_right),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // pointer and sticky error; first error wins
    always_comb begin
        n_sp  = r_sp;
        n_err = r_err;
        if (i_cmd.pop) begin
            if (w_empty) begin
                if (r_err == ST_OK) n_err = ST_UNDER;
            end else begin
                n_sp = w_sp_dec;
            end
        end
        if (i_cmd.push) begin
            if (w_full) begin
                if (r_err == ST_OK) n_err = ST_OVER;
            end else begin
                n_sp = r_sp + 1'b1;
            end
        end
        if (i_cmd.divz && r_err == ST_OK) n_err = ST_DIVZ;
        if (i_cmd.finish) begin
            n_sp  = '0;
            n_err = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp        <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_sp  <= n_sp;
            r_err <= n_err;
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // stack memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !w_full) begin
            r_stack[r_sp[IDX_W-1:0]] <= r_res;
        end
        if (i_cmd.pop) begin
            r_rd <= r_stack[w_sp_dec[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_sym  <= i_in_word.symbol;
            r_last <= i_in_word.last_symbol;
        end
        if (i_cmd.pop)         r_rd_zero <= w_empty;
        if (i_cmd.latch_right) r_right   <= w_opnd;
        if (i_cmd.latch_left)  r_left    <= w_opnd;
        if (i_cmd.set_digit) begin
            r_res <= DATA_W'(r_sym - CH_ZERO);
        end else if (i_cmd.alu) begin
            unique case (w_op)
                OP_ADD:  r_res <= r_left + r_right;
                OP_SUB:  r_res <= r_left - r_right;
                default: r_res <= r_left * r_right;
            endcase
        end else if (i_cmd.divz) begin
            r_res <= '0;
        end else if (i_cmd.load_quot) begin
            r_res <= w_quot;
        end
        if (i_cmd.finish) begin
            r_out_word.value  <= w_opnd;
            r_out_word.status <= r_err;
        end
    end

    assign o_stat.op         = w_op;
    assign o_stat.last       = r_last;
    assign o_stat.right_zero = (r_right == '0);
    assign o_stat.div_done   = w_div_done;
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_out_word        = r_out_word;

    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SP_W'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> (r_sp == '0) && (r_err == ST_OK) && r_out_valid)
        else $error("end of expression did not clear stack");

    a_over_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.push && w_full && r_err == ST_OK && !i_cmd.finish) |=> r_err == ST_OVER)
        else $error("overflow not flagged");

endmodule

@@ hdl/pfx_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfx_ctrl: evaluation sequencer
// Steps one symbol through pop, operate, push and end-of-expression phases.
// ----------------------------------------------------------------------------
module pfx_ctrl
    import pfx_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECODE  = 4'd1;
    localparam logic [3:0] S_POP_R   = 4'd2;
    localparam logic [3:0] S_POP_L   = 4'd3;
    localparam logic [3:0] S_LATCH_L = 4'd4;
    localparam logic [3:0] S_OP      = 4'd5;
    localparam logic [3:0] S_DIV     = 4'd6;
    localparam logic [3:0] S_PUSH    = 4'd7;
    localparam logic [3:0] S_END     = 4'd8;
    localparam logic [3:0] S_FINAL   = 4'd9;

    logic [3:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.op == OP_DIGIT) begin
                    o_cmd.set_digit = 1'b1;
                    n_state         = S_PUSH;
                end else begin
                    n_state = S_POP_R;
                end
            end
            S_POP_R: begin
                o_cmd.pop = 1'b1;
                n_state   = S_POP_L;
            end
            S_POP_L: begin
                o_cmd.pop         = 1'b1;
                o_cmd.latch_right = 1'b1;
                n_state           = S_LATCH_L;
            end
            S_LATCH_L: begin
                o_cmd.latch_left = 1'b1;
                n_state          = S_OP;
            end
            S_OP: begin
                if (i_stat.op == OP_ADD || i_stat.op == OP_SUB || i_stat.op == OP_MUL) begin
                    o_cmd.alu = 1'b1;
                    n_state   = S_PUSH;
                end else if (i_stat.op == OP_DIV) begin
                    if (i_stat.right_zero) begin
                        o_cmd.divz = 1'b1;
                        n_state    = S_PUSH;
                    end else begin
                        o_cmd.div_start = 1'b1;
                        n_state         = S_DIV;
                    end
                end else begin
                    n_state = S_END;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.load_quot = 1'b1;
                    n_state         = S_PUSH;
                end
            end
            S_PUSH: begin
                o_cmd.push = 1'b1;
                n_state    = S_END;
            end
            S_END: begin
                if (i_stat.last) begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_FINAL;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FINAL: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |=> r_state == S_DIV)
        else $error("divide start without wait state");

    a_one_mem_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.pop && o_cmd.push))
        else $error("pop and push in one cycle");

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: postfix_expression_evaluator regression
// Feeds postfix expressions one character word at a time, keeps its own
// operand stack and sticky status to predict each value/status word, and
// checks every result word against the oldest prediction. Directed cases
// cover the empty, full, divide and wrap corners; random expressions then
// run under several sender gap and receiver stall mixes.
// ----------------------------------------------------------------------------
module testbench;
    import pfx_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles before giving up
    localparam int SETTLE_CYCLES  = 60;    // longer than the slowest word
    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
    localparam int MAX_PRINTED    = 100;
    localparam int PHASE_WORDS    = 300;

    // Non-operator characters at both ends of the byte range
    localparam logic [7:0] SYM_LOWEST  = 8'h00;
    localparam logic [7:0] SYM_HIGHEST = 8'hFF;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_word  i_in_word   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_word;

    // Traffic shaping, changed by the test tasks
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_left    = 0;

    int mismatch_count = 0;
    int quiet_cycles   = 0;
    int sent_words     = 0;

    // Predicted copy of the evaluator state
    logic [DATA_W-1:0] calc_stack [STACK_DEPTH];
    int                calc_depth  = 0;
    logic [1:0]        calc_status = ST_OK;
    t_out_word         pending_results [$];

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    postfix_expression_evaluator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Keep only the first error of an expression.
    function automatic void flag_status(logic [1:0] code);
        if (calc_status == ST_OK)
            calc_status = code;
    endfunction

    // Drop the value and flag overflow when all entries are taken.
    function automatic void push_operand(logic [DATA_W-1:0] v);
        if (calc_depth >= STACK_DEPTH) begin
            flag_status(ST_OVER);
        end else begin
            calc_stack[calc_depth] = v;
            calc_depth++;
        end
    endfunction

    // An empty stack reads as zero and flags underflow.
    function automatic logic [DATA_W-1:0] pop_operand();
        if (calc_depth == 0) begin
            flag_status(ST_UNDER);
            return '0;
        end
        calc_depth--;
        return calc_stack[calc_depth];
    endfunction

    // Apply one accepted word; queue a value/status word on the last one.
    function automatic void evaluate_symbol(t_in_word w);
        logic [DATA_W-1:0] rhs;
        logic [DATA_W-1:0] lhs;
        longint            quot;
        t_out_word         res;
        if (w.symbol >= CH_ZERO && w.symbol <= CH_NINE) begin
            push_operand(DATA_W'(w.symbol - CH_ZERO));
        end else begin
            rhs = pop_operand();
            lhs = pop_operand();
            case (w.symbol)
                CH_PLUS:  push_operand(lhs + rhs);
                CH_MINUS: push_operand(lhs - rhs);
                CH_TIMES: push_operand(lhs * rhs);
                CH_SLASH: begin
                    if (rhs == '0) begin
                        flag_status(ST_DIVZ);
                        push_operand('0);
                    end else begin
                        // 64-bit divide: truncates toward zero, and the most
                        // negative value over -1 wraps back to itself
                        quot = longint'($signed(lhs)) / longint'($signed(rhs));
                        push_operand(quot[DATA_W-1:0]);
                    end
                end
                default: ;  // unknown character: both operands are lost
            endcase
        end
        if (w.last_symbol) begin
            res.value  = pop_operand();
            res.status = calc_status;
            pending_results.push_back(res);
            calc_depth  = 0;
            calc_status = ST_OK;
        end
    endfunction

    // Stack depth the evaluator will hold after this character.
    function automatic int depth_after(logic [7:0] sym);
        if (sym >= CH_ZERO && sym <= CH_NINE)
            return (calc_depth < STACK_DEPTH) ? calc_depth + 1 : calc_depth;
        case (sym)
            CH_PLUS, CH_MINUS, CH_TIMES, CH_SLASH:
                return (calc_depth > 2) ? calc_depth - 1 : 1;
            default:
                return (calc_depth > 2) ? calc_depth - 2 : 0;
        endcase
    endfunction

    function automatic logic [7:0] random_digit();
        return CH_ZERO + 8'($urandom_range(9));
    endfunction

    function automatic logic [7:0] random_operator();
        case ($urandom_range(3))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_TIMES;
            default: return CH_SLASH;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("%0t ns: MISMATCH %s", $time, what);
    endtask

    // Compare every accepted result word with the oldest prediction.
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result word value=%0d status=%0d",
                                          o_out_word.value, o_out_word.status));
            end else begin
                want = pending_results.pop_front();
                if (o_out_word.value !== want.value)
                    report_mismatch($sformatf("value got %0d want %0d",
                                              o_out_word.value, want.value));
                if (o_out_word.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              o_out_word.status, want.status));
            end
        end
    end

    // Receiver: hold off for a counted stretch when asked, otherwise stall
    // at the current rate.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    // Watchdog: end the run when neither channel moves for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("postfix_expression_evaluator regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Offer one word, idling first at the sender rate, and return at the
    // edge that accepts it. Valid stays high so the next word can follow
    // back to back; wait_drained lowers it.
    task automatic send_word(input logic [7:0] sym, input logic last);
        t_in_word w;
        w.symbol      = sym;
        w.last_symbol = last;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do
            @(posedge i_clk);
        while (o_in_stall);
        evaluate_symbol(w);
        sent_words++;
    endtask

    // Send a whole expression, marking its final character as last.
    task automatic send_text(input string expr);
        for (int k = 0; k < expr.len(); k++)
            send_word(expr[k], k == expr.len() - 1);
    endtask

    // Drop valid and hold until every predicted word has come back.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Build one random expression. Most are well formed: digits while the
    // stack is shallow, operators to fold it back to a single value, last
    // on the word that leaves one entry. A few go deep enough to overflow,
    // and some mix in raw bytes and end wherever the length runs out.
    task automatic send_random_expression(input bit quick);
        int         length;
        int         depth_cap;
        int         push_pct;
        int         made;
        bit         noisy;
        bit         fin;
        logic [7:0] sym;
        noisy = ($urandom_range(9) == 0);
        if (!quick && $urandom_range(7) == 0) begin
            length    = $urandom_range(24, 40);
            depth_cap = STACK_DEPTH + 1;
            push_pct  = 85;
        end else begin
            length    = $urandom_range(1, quick ? 5 : 12);
            depth_cap = $urandom_range(2, 6);
            push_pct  = 50;
        end
        made = 0;
        fin  = 1'b0;
        while (!fin) begin
            if (noisy && $urandom_range(2) == 0)
                sym = 8'($urandom_range(255));
            else if (calc_depth < 2 || (made < length && calc_depth < depth_cap &&
                                        $urandom_range(99) < push_pct))
                sym = random_digit();
            else
                sym = random_operator();
            made++;
            fin = (made >= length) && (noisy || depth_after(sym) == 1);
            send_word(sym, fin);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // All four operators, with a negative quotient that truncates toward
    // zero: ((9+5)*3-2) / (0-9) = -4.
    task automatic test_arithmetic_ops();
        send_text("95+3*2-09-/");
        send_text("7");
        wait_drained();
    endtask

    // Lone unknown character: both pops and the final pop hit an empty stack.
    task automatic test_empty_stack();
        send_word(SYM_LOWEST, 1'b1);
        wait_drained();
    endtask

    // Divide by zero pushes zero; the later underflow must not replace it
    // as the reported status.
    task automatic test_divide_by_zero();
        send_word(CH_ZERO + 8'd5, 1'b0);
        send_word(CH_ZERO, 1'b0);
        send_word(CH_SLASH, 1'b0);
        send_word(SYM_HIGHEST, 1'b1);
        wait_drained();
    endtask

    // Fill all sixteen entries and push one more, then fold 2 * 8^10 into
    // the most negative value and divide it by -1, which wraps to itself.
    task automatic test_overflow_and_wrap();
        send_text({"2", "8888888888", "11111", "1", "****",
                   "***********", "01-/"});
        wait_drained();
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct,
                                       input int words);
        int start;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        start = sent_words;
        // whole expressions until the phase has sent its share of words
        while (sent_words - start < words)
            send_random_expression(1'b0);
        wait_drained();
    endtask

    // Hold the receiver off while the sender keeps going, so that the
    // output register fills and the block must stall its input.
    task automatic test_output_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_left    = HOLD_CYCLES;
        repeat (12)
            send_random_expression(1'b1);
        wait_drained();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_arithmetic_ops();
        test_empty_stack();
        test_divide_by_zero();
        test_overflow_and_wrap();

        // Each random phase runs until it has sent at least its set number of words.
        test_random_traffic(0, 0, PHASE_WORDS);
        test_random_traffic(45, 0, PHASE_WORDS);
        test_random_traffic(0, 45, PHASE_WORDS);
        test_random_traffic(29, 29, PHASE_WORDS);
        test_output_backpressure();
        test_random_traffic(0, 0, PHASE_WORDS / 3);

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("postfix_expression_evaluator regression: pass");
        else
            $display("postfix_expression_evaluator regression: fail");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/pfx_pkg.sv
hdl/pfx_div.sv
hdl/pfx_dpath.sv
hdl/pfx_ctrl.sv
hdl/postfix_expression_evaluator.sv
verif/testbench.sv
